// ===== rtl/mbcrc_pkg.sv =====
// Package for the Modbus frame CRC appender.
// Holds the CRC-16/MODBUS constants, the byte-fold function and the queue entry type.
// No dependencies.
`default_nettype none

package mbcrc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = 2;
    localparam int unsigned Q_CNT_W   = 3;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } q_entry_t;

    function automatic logic [CRC_W-1:0] crc_fold_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/modbus_frame_crc_appender.sv =====
// Modbus frame CRC appender: echoes frame bytes and appends the CRC-16/MODBUS.
// Depends on mbcrc_pkg for constants, the CRC fold function and the queue entry type.
//
//  channel   dir  ports            payload
//  s_axis    in   tvalid/tready    tdata[7:0] = in_byte
//  m_axis    out  tvalid/tready    tdata[7:0] = out_byte, tlast = frame_end
//
// The byte-wide CRC update sits between the input and a four-entry output queue.
// The last byte of a frame writes three entries at once, so the next input waits
// while the queue drains at one per cycle whenever the output is ready.
// Input is taken while the queue holds at most one entry, even when the output stalls.
// Synchronous active-low reset empties the queue and restarts the CRC and count.
`default_nettype none

module modbus_frame_crc_appender #(
    parameter int unsigned FRAME_BYTES = 6
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast    // frame_end
);

    localparam logic [mbcrc_pkg::POS_W:0] FRAME_LEN = (mbcrc_pkg::POS_W+1)'(FRAME_BYTES);

    logic [mbcrc_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [mbcrc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [mbcrc_pkg::Q_PTR_W-1:0] wptr_reg, wptr_next;
    logic [mbcrc_pkg::Q_PTR_W-1:0] rptr_reg, rptr_next;
    logic [mbcrc_pkg::Q_CNT_W-1:0] count_reg, count_next;
    mbcrc_pkg::q_entry_t           queue_reg [mbcrc_pkg::Q_DEPTH];

    logic                          in_accept;
    logic                          out_accept;
    logic                          frame_close;
    logic [mbcrc_pkg::CRC_W-1:0]   crc_fold;
    logic [mbcrc_pkg::Q_CNT_W-1:0] wr_count;

    assign s_axis_tready = (count_reg <= mbcrc_pkg::Q_CNT_W'(1));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign out_accept    = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = queue_reg[rptr_reg].data;
    assign m_axis_tlast  = queue_reg[rptr_reg].last;

    assign crc_fold    = mbcrc_pkg::crc_fold_byte(crc_reg, s_axis_tdata);
    assign frame_close = (({1'b0, pos_reg} + (mbcrc_pkg::POS_W+1)'(1)) >= FRAME_LEN);

    always_comb begin
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        wr_count  = '0;
        if (in_accept) begin
            if (frame_close) begin
                crc_next = mbcrc_pkg::CRC_INIT;
                pos_next = '0;
                wr_count = mbcrc_pkg::Q_CNT_W'(3);
            end else begin
                crc_next = crc_fold;
                pos_next = pos_reg + mbcrc_pkg::POS_W'(1);
                wr_count = mbcrc_pkg::Q_CNT_W'(1);
            end
        end
        wptr_next  = wptr_reg + wr_count[mbcrc_pkg::Q_PTR_W-1:0];
        rptr_next  = out_accept ? rptr_reg + mbcrc_pkg::Q_PTR_W'(1) : rptr_reg;
        count_next = count_reg + wr_count - mbcrc_pkg::Q_CNT_W'(out_accept);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= mbcrc_pkg::CRC_INIT;
            pos_reg   <= '0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            crc_reg   <= crc_next;
            pos_reg   <= pos_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            queue_reg[wptr_reg] <= '{data: s_axis_tdata, last: 1'b0};
            if (frame_close) begin
                queue_reg[wptr_reg + mbcrc_pkg::Q_PTR_W'(1)] <=
                    '{data: crc_fold[7:0], last: 1'b0};
                queue_reg[wptr_reg + mbcrc_pkg::Q_PTR_W'(2)] <=
                    '{data: crc_fold[15:8], last: 1'b1};
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mbcrc_pkg::Q_CNT_W'(mbcrc_pkg::Q_DEPTH))
        else $error("output queue overflow");

    a_frame_writes_three: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && frame_close) |=>
            (count_reg == $past(count_reg) + mbcrc_pkg::Q_CNT_W'(3)
                          - mbcrc_pkg::Q_CNT_W'($past(out_accept))))
        else $error("frame close did not queue three transactions");

    a_crc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == '0) |-> (crc_reg == mbcrc_pkg::CRC_INIT))
        else $error("CRC not at start value at frame start");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, pos_reg} < FRAME_LEN))
        else $error("byte position beyond frame length");

endmodule

`default_nettype wire

// ===== tb/modbus_frame_crc_appender_tb.sv =====
// Testbench for modbus_frame_crc_appender: streams command bytes into the block and
// checks the echoed bytes and the appended CRC-16/MODBUS against its own CRC tracker.
// Depends on mbcrc_pkg and the RTL of modbus_frame_crc_appender.
`timescale 1ns / 1ps

module modbus_frame_crc_appender_tb;

    localparam int unsigned FRAME_LEN   = 6;
    localparam int unsigned RAND_BYTES  = 180;
    localparam int unsigned HOLD_AT     = 60;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [mbcrc_pkg::BYTE_W-1:0] data;
        logic                         wait_drain;
    } cmd_byte_t;

    typedef struct packed {
        logic [mbcrc_pkg::BYTE_W-1:0] out_byte;
        logic                         frame_end;
    } frame_beat_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [mbcrc_pkg::BYTE_W-1:0] s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [mbcrc_pkg::BYTE_W-1:0] m_axis_tdata;
    logic                         m_axis_tlast;

    cmd_byte_t   bytes_to_send[$];
    frame_beat_t beats_due[$];

    logic [mbcrc_pkg::CRC_W-1:0] crc_run = mbcrc_pkg::CRC_INIT;
    logic [mbcrc_pkg::POS_W-1:0] pos_in_frame = '0;

    int unsigned sent_cnt     = 0;
    int unsigned got_cnt      = 0;
    int unsigned frames_done  = 0;
    int unsigned err_cnt      = 0;
    int unsigned hold_left    = 0;
    int unsigned cycle_cnt    = 0;
    logic        sender_calm  = 1'b0;
    logic        recv_calm    = 1'b0;
    frame_beat_t beat_seen;
    frame_beat_t beat_want;
    cmd_byte_t   byte_next;

    modbus_frame_crc_appender #(
        .FRAME_BYTES(FRAME_LEN)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [mbcrc_pkg::CRC_W-1:0] crc16_fold(
        input logic [mbcrc_pkg::CRC_W-1:0]  crc,
        input logic [mbcrc_pkg::BYTE_W-1:0] b
    );
        logic [mbcrc_pkg::CRC_W-1:0] acc;
        acc = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            acc = acc[0] ? ((acc >> 1) ^ mbcrc_pkg::CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    task automatic predict_frame_byte(input logic [mbcrc_pkg::BYTE_W-1:0] b);
        logic [mbcrc_pkg::CRC_W-1:0] next_crc;
        next_crc = crc16_fold(crc_run, b);
        beats_due.push_back('{out_byte: b, frame_end: 1'b0});
        if (int'(pos_in_frame) + 1 >= FRAME_LEN) begin
            beats_due.push_back('{out_byte: next_crc[7:0], frame_end: 1'b0});
            beats_due.push_back('{out_byte: next_crc[15:8], frame_end: 1'b1});
            crc_run      = mbcrc_pkg::CRC_INIT;
            pos_in_frame = '0;
        end else begin
            crc_run      = next_crc;
            pos_in_frame = pos_in_frame + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input frame_beat_t want,
                                   input frame_beat_t seen);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, what, want.out_byte, want.frame_end,
                     seen.out_byte, seen.frame_end);
        end
    endtask

    task automatic queue_byte(input logic [mbcrc_pkg::BYTE_W-1:0] b,
                              input logic wait_drain);
        bytes_to_send.push_back('{data: b, wait_drain: wait_drain});
    endtask

    // driver: offer the next byte, hold it until the transaction completes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            crc_run       = mbcrc_pkg::CRC_INIT;
            pos_in_frame  = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_frame_byte(s_axis_tdata);
                sent_cnt++;
            end
            sender_calm = (sent_cnt >= 100 && sent_cnt < 160);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (bytes_to_send.size() > 0 && bytes_to_send[0].wait_drain
                        && beats_due.size() == 0) begin
                    bytes_to_send[0].wait_drain = 1'b0;
                end
                if (bytes_to_send.size() == 0 || bytes_to_send[0].wait_drain
                        || (!sender_calm && $urandom_range(0, 99) < 6)) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    byte_next      = bytes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= byte_next.data;
                end
            end
        end
    end

    // monitor: check each output transaction, drive backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_cnt++;
                beat_seen = '{out_byte: m_axis_tdata, frame_end: m_axis_tlast};
                if (beats_due.size() == 0) begin
                    report_mismatch("unexpected output", '0, beat_seen);
                end else begin
                    beat_want = beats_due.pop_front();
                    if (beat_seen.out_byte !== beat_want.out_byte)
                        report_mismatch("out_byte mismatch", beat_want, beat_seen);
                    if (beat_seen.frame_end !== beat_want.frame_end)
                        report_mismatch("frame_end mismatch", beat_want, beat_seen);
                    if (beat_want.frame_end)
                        frames_done++;
                end
                if (got_cnt == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            recv_calm = (got_cnt >= 150 && got_cnt < 230);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= recv_calm || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [mbcrc_pkg::BYTE_W-1:0] b;
        // all zeros, all ones, walking ones, alternating patterns, 7F and FE
        for (int i = 0; i < FRAME_LEN; i++) queue_byte(8'h00, 1'b0);
        for (int i = 0; i < FRAME_LEN; i++) queue_byte(8'hFF, 1'b0);
        for (int i = 0; i < 8; i++) queue_byte(8'h01 << i, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hFE, 1'b0);
        for (int i = 0; i < RAND_BYTES; i++) begin
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            queue_byte(b, (i == 0) || (i == RAND_BYTES / 2));
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_to_send.size() > 0 || s_axis_tvalid || beats_due.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (beats_due.size() > 0)
            report_mismatch("missing output", beats_due[0], '0);
        $display("Streamed %0d command bytes in %0d-byte frames; checked %0d output bytes",
                 sent_cnt, FRAME_LEN, got_cnt);
        $display("Closed %0d frames with CRC, incl. a long output stall and a drain pause",
                 frames_done);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Mismatches: %0d", err_cnt);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mbcrc_pkg.sv
rtl/modbus_frame_crc_appender.sv
tb/modbus_frame_crc_appender_tb.sv
